// ===== rtl/core/bounded_array_list_engine_defines.svh =====
// Assertion helpers for the array list engine.
`ifndef BOUNDED_ARRAY_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define BALE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define BALE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bale_pkg.sv =====
package bale_pkg;

    // Field widths
    localparam int DATA_W   = 32;
    localparam int TYPE_W   = 4;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 4;
    localparam int COUNT_W  = 5;

    localparam int DEPTH_DEFAULT = 16;

    // Request codes
    localparam logic [TYPE_W-1:0] REQ_APPEND     = 4'd0;
    localparam logic [TYPE_W-1:0] REQ_INSERT_AT  = 4'd1;
    localparam logic [TYPE_W-1:0] REQ_INSERT_ORD = 4'd2;
    localparam logic [TYPE_W-1:0] REQ_GET        = 4'd3;
    localparam logic [TYPE_W-1:0] REQ_SET        = 4'd4;
    localparam logic [TYPE_W-1:0] REQ_FIND       = 4'd5;
    localparam logic [TYPE_W-1:0] REQ_REMOVE_VAL = 4'd6;
    localparam logic [TYPE_W-1:0] REQ_REMOVE_AT  = 4'd7;
    localparam logic [TYPE_W-1:0] REQ_BSEARCH    = 4'd8;
    localparam logic [TYPE_W-1:0] REQ_CLEAR      = 4'd9;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [TYPE_W-1:0]        req_type;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] data_out;
        logic [IDX_W-1:0]         index_out;
        logic [COUNT_W-1:0]       item_count;
    } rsp_t;

endpackage

// ===== rtl/core/bale_stream_if.sv =====
interface bale_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

// ===== rtl/core/bounded_array_list_engine.sv =====
// Fixed-capacity array list of up to DEPTH signed 32-bit words. One request is
// taken while the engine is idle; it then runs on a small sequencer around an
// element memory with one write port and one registered read port, and the
// result goes to an output register that holds it until the sink takes it,
// while the next request may already be accepted. Clear, set, append, unknown
// codes and rejected requests go straight to the output step; get does one
// read; find reads and compares each entry from the front until a hit or the
// end; remove_at and remove_value then move each later entry down one place;
// insert_at and insert_ordered move entries up one place from the end until
// the slot is reached; binary search probes until a hit or an empty window
// (at most log2(DEPTH)+1 probes). A finished request waits while the sink
// holds off the previous result. Every step is set by the one memory read
// port and its registered read. The memory needs no clearing after reset,
// since only entries below the count are read.
`include "bounded_array_list_engine_defines.svh"

module bounded_array_list_engine
    import bale_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    bale_stream_if.sink         req,
    bale_stream_if.source       rsp
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int AW   = $clog2(DEPTH);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GET_RD,
        S_RM_AT,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FIND_RD,
        S_FIND_CMP,
        S_INS_RD,
        S_INS_CMP,
        S_BS_RD,
        S_BS_CMP,
        S_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [TYPE_W-1:0]        op_reg, op_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    logic [CMPW-1:0]          pos_reg, pos_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            ptr_reg, ptr_next;
    logic [CW-1:0]            lo_reg, lo_next;
    logic [CW-1:0]            hi_reg, hi_next;
    logic [CW-1:0]            mid_reg, mid_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic signed [DATA_W-1:0] data_reg, data_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic                     out_valid_reg, out_valid_next;
    rsp_t                     out_reg, out_next;

    // Element memory: one write port, one registered read port
    logic [DATA_W-1:0]        mem [DEPTH];
    logic signed [DATA_W-1:0] rdata_reg;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [DATA_W-1:0]        wr_data;
    logic [AW-1:0]            rd_addr;

    logic                     req_xfer;
    logic [CMPW-1:0]          req_pos;
    logic [CMPW-1:0]          count_ext;
    logic [CMPW-1:0]          ptr_ext;
    logic [CW-1:0]            ptr_inc;
    logic [CW-1:0]            ptr_dec;
    logic [CW-1:0]            mid_calc;
    logic                     full;

    assign req_xfer  = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign req_pos   = CMPW'(req.data.position);
    assign count_ext = CMPW'(count_reg);
    assign ptr_ext   = CMPW'(ptr_reg);
    assign ptr_inc   = ptr_reg + 1'b1;
    assign ptr_dec   = ptr_reg - 1'b1;
    assign mid_calc  = lo_reg + ((hi_reg - lo_reg - 1'b1) >> 1);
    assign full      = (count_reg == CW'(DEPTH));

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // Memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        value_next     = value_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        status_next    = status_reg;
        data_next      = data_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        wr_en          = 1'b0;
        wr_addr        = ptr_reg[AW-1:0];
        wr_data        = value_reg;
        rd_addr        = ptr_reg[AW-1:0];

        // Drop the result once the sink takes it
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    op_next     = req.data.req_type;
                    value_next  = req.data.value;
                    pos_next    = req_pos;
                    status_next = ST_OK;
                    data_next   = '0;
                    idx_next    = '0;
                    state_next  = S_DONE;
                    case (req.data.req_type)
                        REQ_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = count_reg[AW-1:0];
                                wr_data    = req.data.value;
                                data_next  = req.data.value;
                                idx_next   = IDX_W'(count_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        REQ_INSERT_AT, REQ_INSERT_ORD:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (req.data.req_type == REQ_INSERT_AT &&
                                     req_pos > count_ext)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                ptr_next   = count_reg;
                                state_next = S_INS_RD;
                            end
                        end
                        REQ_GET, REQ_SET, REQ_REMOVE_AT:
                        begin
                            if (req_pos >= count_ext)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else if (req.data.req_type == REQ_SET)
                            begin
                                wr_en     = 1'b1;
                                wr_addr   = req_pos[AW-1:0];
                                wr_data   = req.data.value;
                                data_next = req.data.value;
                                idx_next  = IDX_W'(req_pos);
                            end
                            else
                            begin
                                rd_addr = req_pos[AW-1:0];
                                if (req.data.req_type == REQ_GET)
                                begin
                                    state_next = S_GET_RD;
                                end
                                else
                                begin
                                    state_next = S_RM_AT;
                                end
                            end
                        end
                        REQ_FIND, REQ_REMOVE_VAL:
                        begin
                            ptr_next   = '0;
                            state_next = S_FIND_RD;
                        end
                        REQ_BSEARCH:
                        begin
                            lo_next    = '0;
                            hi_next    = count_reg;
                            state_next = S_BS_RD;
                        end
                        REQ_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_GET_RD:
            begin
                data_next  = rdata_reg;
                idx_next   = IDX_W'(pos_reg);
                state_next = S_DONE;
            end

            S_RM_AT:
            begin
                data_next  = rdata_reg;
                idx_next   = IDX_W'(pos_reg);
                ptr_next   = pos_reg[CW-1:0];
                state_next = S_SHIFT_RD;
            end

            // Close the gap: move entry ptr+1 down to ptr
            S_SHIFT_RD:
            begin
                if (ptr_inc < count_reg)
                begin
                    rd_addr    = ptr_inc[AW-1:0];
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
            end

            S_SHIFT_WR:
            begin
                wr_en      = 1'b1;
                wr_data    = rdata_reg;
                ptr_next   = ptr_inc;
                state_next = S_SHIFT_RD;
            end

            // Linear scan for the first match
            S_FIND_RD:
            begin
                if (ptr_reg < count_reg)
                begin
                    state_next = S_FIND_CMP;
                end
                else
                begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_DONE;
                end
            end

            S_FIND_CMP:
            begin
                if (rdata_reg == value_reg)
                begin
                    data_next = value_reg;
                    idx_next  = IDX_W'(ptr_reg);
                    if (op_reg == REQ_REMOVE_VAL)
                    begin
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    ptr_next   = ptr_inc;
                    state_next = S_FIND_RD;
                end
            end

            // Open the gap: move entry ptr-1 up to ptr until the slot is found
            S_INS_RD:
            begin
                if (ptr_reg == '0 || (op_reg == REQ_INSERT_AT && ptr_ext == pos_reg))
                begin
                    wr_en      = 1'b1;
                    data_next  = value_reg;
                    idx_next   = IDX_W'(ptr_reg);
                    count_next = count_reg + 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_addr    = ptr_dec[AW-1:0];
                    state_next = S_INS_CMP;
                end
            end

            S_INS_CMP:
            begin
                wr_en = 1'b1;
                if (op_reg == REQ_INSERT_ORD && rdata_reg <= value_reg)
                begin
                    data_next  = value_reg;
                    idx_next   = IDX_W'(ptr_reg);
                    count_next = count_reg + 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    wr_data    = rdata_reg;
                    ptr_next   = ptr_dec;
                    state_next = S_INS_RD;
                end
            end

            // Binary search over the half-open window [lo, hi)
            S_BS_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_addr    = mid_calc[AW-1:0];
                    mid_next   = mid_calc;
                    state_next = S_BS_CMP;
                end
                else
                begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_DONE;
                end
            end

            S_BS_CMP:
            begin
                if (rdata_reg == value_reg)
                begin
                    data_next  = value_reg;
                    idx_next   = IDX_W'(mid_reg);
                    state_next = S_DONE;
                end
                else
                begin
                    if (rdata_reg < value_reg)
                    begin
                        lo_next = mid_reg + 1'b1;
                    end
                    else
                    begin
                        hi_next = mid_reg;
                    end
                    state_next = S_BS_RD;
                end
            end

            // Load the output register once it is free
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next.status     = status_reg;
                    out_next.data_out   = data_reg;
                    out_next.index_out  = idx_reg;
                    out_next.item_count = COUNT_W'(count_reg);
                    out_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= '0;
            value_reg     <= '0;
            pos_reg       <= '0;
            count_reg     <= '0;
            ptr_reg       <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
            status_reg    <= ST_OK;
            data_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            value_reg     <= value_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            ptr_reg       <= ptr_next;
            lo_reg        <= lo_next;
            hi_reg        <= hi_next;
            mid_reg       <= mid_next;
            status_reg    <= status_next;
            data_reg      <= data_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    // Checks
    `BALE_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(DEPTH),
        "count above depth")
    `BALE_ASSERT_NEXT(a_clear_empties, clk, rst_n,
        req_xfer && req.data.req_type == REQ_CLEAR, count_reg == '0,
        "clear left entries")
    `BALE_ASSERT_IMP(a_full_count, clk, rst_n,
        rsp.valid && rsp.data.status == ST_FULL,
        rsp.data.item_count == COUNT_W'(DEPTH), "full reported below capacity")
    `BALE_ASSERT_IMP(a_fail_zero, clk, rst_n,
        rsp.valid && rsp.data.status != ST_OK,
        rsp.data.data_out == '0 && rsp.data.index_out == '0,
        "failed request carries data")

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import bale_pkg::*;

    localparam int DEPTH       = DEPTH_DEFAULT;
    localparam int IDLE_PCT    = 22;
    localparam int TAIL_CYCLES = 60;
    localparam int CYCLE_LIMIT = 400000;

    // Request codes the block does not decode
    localparam logic [TYPE_W-1:0] REQ_UNKNOWN_LO = 4'd10;
    localparam logic [TYPE_W-1:0] REQ_UNKNOWN_HI = 4'd15;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic [POS_W-1:0]         POS_TOP = {POS_W{1'b1}};

    logic clk;
    logic rst_n;
    bit   quiet_mode;

    bale_stream_if #(.payload_t(req_t)) req_if ();
    bale_stream_if #(.payload_t(rsp_t)) rsp_if ();

    bounded_array_list_engine #(
        .DEPTH (DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Shadow copy of the list held by the block
    logic signed [DATA_W-1:0] list_mem [DEPTH];
    int                       list_len;

    rsp_t awaited_responses [$];
    rsp_t want;
    int   mismatch_count;
    int   cycle_count;
    int   requests_taken;
    int   responses_seen;
    int   req_type_seen [16];
    int   status_seen [4];

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Apply one request to the shadow list and return the response it yields
    function automatic rsp_t next_list_response(input req_t r);
        rsp_t                     res;
        logic signed [DATA_W-1:0] key;
        int                       slot;
        int                       lo;
        int                       hi;
        int                       mid;
        bit                       hit;
        res = '0;
        key = r.value;
        hit = 1'b0;
        case (r.req_type)
            REQ_APPEND:
            begin
                if (list_len >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    list_mem[list_len] = key;
                    res.index_out = list_len[IDX_W-1:0];
                    res.data_out = key;
                    list_len++;
                end
            end
            REQ_INSERT_AT:
            begin
                if (list_len >= DEPTH)
                    res.status = ST_FULL;
                else if (int'(r.position) > list_len)
                    res.status = ST_BADPOS;
                else
                begin
                    for (slot = list_len; slot > int'(r.position); slot--)
                        list_mem[slot] = list_mem[slot - 1];
                    list_mem[r.position] = key;
                    list_len++;
                    res.data_out = key;
                    res.index_out = r.position[IDX_W-1:0];
                end
            end
            REQ_INSERT_ORD:
            begin
                if (list_len >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    // Move strictly larger entries up; equal keys stay in front
                    slot = list_len;
                    while (slot > 0 && list_mem[slot - 1] > key)
                    begin
                        list_mem[slot] = list_mem[slot - 1];
                        slot--;
                    end
                    list_mem[slot] = key;
                    list_len++;
                    res.data_out = key;
                    res.index_out = slot[IDX_W-1:0];
                end
            end
            REQ_GET, REQ_SET, REQ_REMOVE_AT:
            begin
                if (int'(r.position) >= list_len)
                    res.status = ST_BADPOS;
                else
                begin
                    res.index_out = r.position[IDX_W-1:0];
                    if (r.req_type == REQ_SET)
                        list_mem[r.position] = key;
                    res.data_out = list_mem[r.position];
                    if (r.req_type == REQ_REMOVE_AT)
                    begin
                        for (slot = r.position; slot + 1 < list_len; slot++)
                            list_mem[slot] = list_mem[slot + 1];
                        list_len--;
                    end
                end
            end
            REQ_FIND, REQ_REMOVE_VAL:
            begin
                for (slot = 0; slot < list_len && !hit; slot++)
                begin
                    if (list_mem[slot] == key)
                    begin
                        hit = 1'b1;
                        res.index_out = slot[IDX_W-1:0];
                    end
                end
                if (!hit)
                    res.status = ST_NOTFOUND;
                else
                begin
                    res.data_out = key;
                    if (r.req_type == REQ_REMOVE_VAL)
                    begin
                        for (slot = res.index_out; slot + 1 < list_len; slot++)
                            list_mem[slot] = list_mem[slot + 1];
                        list_len--;
                    end
                end
            end
            REQ_BSEARCH:
            begin
                // Halving probes over the half-open window, sorted or not
                lo = 0;
                hi = list_len;
                while (lo < hi && !hit)
                begin
                    mid = lo + (hi - lo - 1) / 2;
                    if (list_mem[mid] == key)
                    begin
                        hit = 1'b1;
                        res.index_out = mid[IDX_W-1:0];
                    end
                    else if (list_mem[mid] < key)
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                if (hit)
                    res.data_out = key;
                else
                    res.status = ST_NOTFOUND;
            end
            REQ_CLEAR:
                list_len = 0;
            default:
                ;
        endcase
        res.item_count = list_len[COUNT_W-1:0];
        return res;
    endfunction

    task automatic report_error(input string msg);
        mismatch_count++;
        $display("[%0t] ERROR: %s", $time, msg);
    endtask

    // Predict on each request transfer, check each response transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count++;
            if (req_if.valid && req_if.ready)
            begin
                awaited_responses.push_back(next_list_response(req_if.data));
                req_type_seen[req_if.data.req_type]++;
                requests_taken++;
            end
            if (rsp_if.valid && rsp_if.ready)
            begin
                responses_seen++;
                if (awaited_responses.size() == 0)
                    report_error($sformatf("response %0d arrived with no request pending",
                                           responses_seen));
                else
                begin
                    want = awaited_responses.pop_front();
                    if (rsp_if.data.status !== want.status)
                        report_error($sformatf("response %0d status: got %0d, expected %0d",
                                               responses_seen, rsp_if.data.status,
                                               want.status));
                    else
                        status_seen[want.status]++;
                    if (rsp_if.data.data_out !== want.data_out)
                        report_error($sformatf("response %0d data_out: got %0d, expected %0d",
                                               responses_seen, rsp_if.data.data_out,
                                               want.data_out));
                    if (rsp_if.data.index_out !== want.index_out)
                        report_error($sformatf("response %0d index_out: got %0d, expected %0d",
                                               responses_seen, rsp_if.data.index_out,
                                               want.index_out));
                    if (rsp_if.data.item_count !== want.item_count)
                        report_error($sformatf("response %0d item_count: got %0d, expected %0d",
                                               responses_seen, rsp_if.data.item_count,
                                               want.item_count));
                end
            end
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("[%0t] ERROR: run stalled, %0d responses outstanding", $time,
                         awaited_responses.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Stall the response side at random unless in a quiet stretch
    initial
    begin
        rsp_if.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            rsp_if.ready = quiet_mode || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Drive one request and hold it until the transfer
    task automatic send_request(input logic [TYPE_W-1:0] kind,
                                input logic signed [DATA_W-1:0] val,
                                input logic [POS_W-1:0] pos);
        req_t item;
        item.req_type = kind;
        item.value    = val;
        item.position = pos;
        while (!quiet_mode && $urandom_range(99) < IDLE_PCT)
        begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.data  = item;
        req_if.valid = 1'b1;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        @(negedge clk);
        req_if.valid = 1'b0;
    endtask

    // Mix of small keys (for duplicates), extremes, held entries and full-range words
    function automatic logic signed [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30 && list_len > 0)
            return list_mem[$urandom_range(list_len - 1)];
        if (roll < 55)
            return int'($urandom_range(16)) - 8;
        if (roll < 65)
        begin
            case ($urandom_range(4))
                0: return VAL_MAX;
                1: return VAL_MIN;
                2: return '0;
                3: return -1;
                default: return 1;
            endcase
        end
        return $urandom;
    endfunction

    // Mostly positions from 0 up to the list length, some past the end, some anywhere in the field
    function automatic logic [POS_W-1:0] pick_pos();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return POS_W'($urandom_range(list_len));
        if (roll < 90)
            return POS_W'($urandom_range(DEPTH, list_len));
        return POS_W'($urandom_range(POS_TOP));
    endfunction

    task automatic wait_idle();
        while (awaited_responses.size() != 0)
            @(negedge clk);
    endtask

    // Empty-list rejects, extremes, shifts at both ends, equal keys, unknown codes
    task automatic test_edge_cases();
        send_request(REQ_GET, 32'sd5, '0);
        send_request(REQ_REMOVE_AT, 32'sd5, '0);
        send_request(REQ_FIND, 32'sd5, '0);
        send_request(REQ_BSEARCH, 32'sd5, '0);
        send_request(REQ_REMOVE_VAL, 32'sd5, '0);
        send_request(REQ_INSERT_AT, 32'sd5, 5'd1);
        send_request(REQ_APPEND, VAL_MAX, POS_TOP);
        send_request(REQ_APPEND, VAL_MIN, '0);
        send_request(REQ_INSERT_AT, '0, '0);
        send_request(REQ_INSERT_AT, -1, 5'd3);
        send_request(REQ_INSERT_AT, 32'sd7, POS_TOP);
        send_request(REQ_SET, 32'sh5A5A_5A5A, 5'd1);
        send_request(REQ_GET, '0, 5'd4);
        send_request(REQ_GET, '0, 5'd16);
        send_request(REQ_FIND, -1, '0);
        send_request(REQ_REMOVE_AT, '0, 5'd4);
        send_request(REQ_REMOVE_VAL, '0, '0);
        send_request(REQ_UNKNOWN_LO, VAL_MAX, POS_TOP);
        send_request(REQ_UNKNOWN_HI, VAL_MIN, '0);
        send_request(REQ_CLEAR, VAL_MAX, POS_TOP);
        send_request(REQ_INSERT_ORD, 32'sd10, '0);
        send_request(REQ_INSERT_ORD, -32'sd10, '0);
        send_request(REQ_INSERT_ORD, 32'sd10, '0);
        send_request(REQ_INSERT_ORD, VAL_MIN, '0);
        send_request(REQ_INSERT_ORD, VAL_MAX, '0);
        send_request(REQ_BSEARCH, 32'sd10, '0);
        send_request(REQ_BSEARCH, 32'sd3, '0);
        send_request(REQ_BSEARCH, VAL_MAX, '0);
    endtask

    // Fill to capacity, hit every full reject, then empty it again
    task automatic test_capacity(input int rounds);
        repeat (rounds)
        begin
            send_request(REQ_CLEAR, pick_value(), pick_pos());
            while (list_len < DEPTH)
            begin
                case ($urandom_range(2))
                    0: send_request(REQ_APPEND, pick_value(), pick_pos());
                    1: send_request(REQ_INSERT_AT, pick_value(),
                                    POS_W'($urandom_range(list_len)));
                    default: send_request(REQ_INSERT_ORD, pick_value(), pick_pos());
                endcase
            end
            send_request(REQ_APPEND, pick_value(), pick_pos());
            send_request(REQ_INSERT_AT, pick_value(), POS_W'(DEPTH));
            send_request(REQ_INSERT_AT, pick_value(), POS_W'($urandom_range(POS_TOP)));
            send_request(REQ_INSERT_ORD, pick_value(), pick_pos());
            send_request(REQ_GET, pick_value(), POS_W'(DEPTH - 1));
            send_request(REQ_SET, pick_value(), POS_W'(DEPTH - 1));
            send_request(REQ_GET, pick_value(), POS_W'(DEPTH));
            send_request(REQ_REMOVE_AT, pick_value(), POS_W'(DEPTH - 1));
            send_request(REQ_REMOVE_AT, pick_value(), '0);
            while (list_len > 0)
            begin
                if ($urandom_range(1))
                    send_request(REQ_REMOVE_VAL, list_mem[$urandom_range(list_len - 1)],
                                 pick_pos());
                else
                    send_request(REQ_REMOVE_AT, pick_value(),
                                 POS_W'($urandom_range(list_len - 1)));
            end
        end
    endtask

    // Keep the list ascending so binary search sees well-formed data
    task automatic test_sorted_list(input int n);
        int                roll;
        logic [TYPE_W-1:0] kind;
        send_request(REQ_CLEAR, pick_value(), pick_pos());
        repeat (n)
        begin
            roll = $urandom_range(99);
            if (roll < 2)
                kind = REQ_CLEAR;
            else if (list_len < 3 || roll < 40)
                kind = REQ_INSERT_ORD;
            else if (roll < 65)
                kind = REQ_BSEARCH;
            else if (roll < 75)
                kind = REQ_FIND;
            else if (roll < 85)
                kind = REQ_REMOVE_VAL;
            else if (roll < 93)
                kind = REQ_REMOVE_AT;
            else
                kind = REQ_GET;
            send_request(kind, pick_value(), pick_pos());
        end
    endtask

    // Any request in any order, including unknown codes and unsorted searches
    task automatic test_random_mix(input int n);
        int                roll;
        logic [TYPE_W-1:0] kind;
        repeat (n)
        begin
            roll = $urandom_range(99);
            if (roll < 3)
                kind = TYPE_W'($urandom_range(REQ_UNKNOWN_HI, REQ_UNKNOWN_LO));
            else if (roll < 5)
                kind = REQ_CLEAR;
            else if (roll < 25 && list_len < DEPTH / 2)
                kind = REQ_APPEND;
            else
                kind = TYPE_W'($urandom_range(REQ_BSEARCH, REQ_APPEND));
            send_request(kind, pick_value(), pick_pos());
        end
    endtask

    // Same mix with both sides running flat out
    task automatic test_back_to_back(input int n);
        quiet_mode = 1'b1;
        test_random_mix(n);
        wait_idle();
        quiet_mode = 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        quiet_mode    = 1'b0;
        req_if.valid  = 1'b0;
        req_if.data   = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_edge_cases();
        test_capacity(4);
        test_sorted_list(450);
        test_random_mix(650);
        test_back_to_back(250);

        // Drain, then watch for stray responses
        wait_idle();
        repeat (TAIL_CYCLES) @(negedge clk);

        $write("Covered %0d requests and %0d responses over %0d cycles; ",
               requests_taken, responses_seen, cycle_count);
        $display("ok %0d, full %0d, bad position %0d, not found %0d.",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_BADPOS],
                 status_seen[ST_NOTFOUND]);
        $write("Requests by kind: append %0d, insert %0d, ordered insert %0d, get %0d, ",
               req_type_seen[REQ_APPEND], req_type_seen[REQ_INSERT_AT],
               req_type_seen[REQ_INSERT_ORD], req_type_seen[REQ_GET]);
        $display("set %0d, find %0d, remove value %0d, remove at %0d, search %0d, clear %0d.",
                 req_type_seen[REQ_SET], req_type_seen[REQ_FIND],
                 req_type_seen[REQ_REMOVE_VAL], req_type_seen[REQ_REMOVE_AT],
                 req_type_seen[REQ_BSEARCH], req_type_seen[REQ_CLEAR]);
        if (mismatch_count == 0 && awaited_responses.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
